// ----- design/crt_pkg.sv -----
// Shared types and constants for the command reply tracker.
// Used by crt_eval and command_reply_tracker_unit; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package crt_pkg;

    localparam int NUM_SLOTS  = 5;
    localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam int SLOT_W     = 3;
    localparam int SEQ_W      = 32;
    localparam int RSEQ_W     = 16;
    localparam int TIME_W     = 32;
    localparam int MASK_W     = 5;
    localparam int OUTCOME_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = TIME_W'(1000);
    localparam logic [MASK_W-1:0] SILENT_RESET  = MASK_W'(3);

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SILENT  = CFG_IDX_W'(1);

    localparam logic FUNC_SEND  = 1'b0;
    localparam logic FUNC_REPLY = 1'b1;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_SENT         = 3'd0,
        OUT_SENT_TIMEOUT = 3'd1,
        OUT_BUSY         = 3'd2,
        OUT_MATCHED      = 3'd3,
        OUT_INACTIVE     = 3'd4,
        OUT_OLDER        = 3'd5,
        OUT_NEWER        = 3'd6
    } outcome_t;

    typedef struct packed {
        logic              func;
        logic [SLOT_W-1:0] slot;
        logic [SEQ_W-1:0]  seq;
        logic [RSEQ_W-1:0] reply_seq;
        logic              want_response;
        logic [TIME_W-1:0] now_ms;
    } item_t;

    typedef struct packed {
        logic              active;
        logic              wants;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] sent_time;
    } slot_entry_t;

    typedef struct packed {
        logic        wr;
        slot_entry_t entry;
    } slot_update_t;

    typedef struct packed {
        outcome_t          outcome;
        logic              response_valid;
        logic              response_ok;
        logic [SLOT_W-1:0] response_slot;
        logic [SEQ_W-1:0]  response_seq;
    } result_t;

endpackage

`default_nettype wire

// ----- design/crt_eval.sv -----
// Decision logic for one tracker request against the state of its slot.
// Depends on crt_pkg for item, entry, update and result types.
`timescale 1ns / 1ps
`default_nettype none

module crt_eval (
    input  wire crt_pkg::item_t              item,
    input  wire crt_pkg::slot_entry_t        entry,
    input  wire logic [crt_pkg::TIME_W-1:0]  timeout_ms,
    input  wire logic [crt_pkg::MASK_W-1:0]  silent_mask,
    output crt_pkg::result_t                 result,
    output crt_pkg::slot_update_t            update
);

    logic                       in_range;
    logic [crt_pkg::TIME_W-1:0] waited;
    logic                       timed_out;
    logic [crt_pkg::MASK_W-1:0] silent_shift;
    logic                       may_respond;
    logic                       seq_equal;
    logic                       seq_older;

    always_comb begin
        in_range     = int'(item.slot) < crt_pkg::NUM_SLOTS;
        waited       = item.now_ms - entry.sent_time;
        timed_out    = waited >= timeout_ms;
        // Shifting past the mask yields zero, so high slots are never silent.
        silent_shift = silent_mask >> item.slot;
        may_respond  = entry.wants && !silent_shift[0];
        seq_equal    = item.reply_seq == entry.seq[crt_pkg::RSEQ_W-1:0];
        seq_older    = item.reply_seq <  entry.seq[crt_pkg::RSEQ_W-1:0];

        result.outcome        = crt_pkg::OUT_SENT;
        result.response_valid = 1'b0;
        result.response_ok    = 1'b0;
        result.response_slot  = '0;
        result.response_seq   = '0;
        update.wr             = 1'b0;
        update.entry          = '0;

        if (!in_range) begin
            result.outcome = (item.func == crt_pkg::FUNC_REPLY) ? crt_pkg::OUT_INACTIVE
                                                                 : crt_pkg::OUT_BUSY;
        end else if (item.func == crt_pkg::FUNC_SEND) begin
            if (entry.active && !timed_out) begin
                result.outcome = crt_pkg::OUT_BUSY;
            end else begin
                result.outcome = entry.active ? crt_pkg::OUT_SENT_TIMEOUT : crt_pkg::OUT_SENT;
                // A timed-out release reports an error for the old command if it may respond.
                result.response_valid = entry.active && may_respond;
                update.wr              = 1'b1;
                update.entry.active    = 1'b1;
                update.entry.wants     = item.want_response;
                update.entry.seq       = item.seq;
                update.entry.sent_time = item.now_ms;
            end
        end else begin
            if (!entry.active) begin
                result.outcome = crt_pkg::OUT_INACTIVE;
            end else if (seq_older) begin
                result.outcome = crt_pkg::OUT_OLDER;
            end else begin
                result.outcome        = seq_equal ? crt_pkg::OUT_MATCHED : crt_pkg::OUT_NEWER;
                result.response_valid = may_respond;
                result.response_ok    = may_respond && seq_equal;
                update.wr             = 1'b1;
            end
        end

        if (result.response_valid) begin
            result.response_slot = item.slot;
            result.response_seq  = entry.seq;
        end
    end

endmodule

`default_nettype wire

// ----- design/command_reply_tracker_unit.sv -----
// Top level of the command reply tracker: input register, slot state,
// configuration registers and result register. Depends on crt_pkg, crt_eval.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Content
// s_        in         s_valid / s_ready    send or reply request
// m_        out        m_valid / m_ready    one result per request
// cfg_      in         cfg_valid / cfg_ready register index and write data
//
// A request is captured in an input register and evaluated there. It moves
// into the result register when that is empty or being emptied, so one
// request per cycle is sustained while results are taken. The slot state is
// updated in that move, so the next request always sees it. Reset clears
// all slot flags and returns the timeout and silent mask to their defaults. A
// stalled result holds the result register; the input register still takes
// one further request and then ready drops until the result is taken.

module command_reply_tracker_unit (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,

    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_func,
    input  wire logic [crt_pkg::SLOT_W-1:0]       s_slot,
    input  wire logic [crt_pkg::SEQ_W-1:0]        s_seq,
    input  wire logic [crt_pkg::RSEQ_W-1:0]       s_reply_seq,
    input  wire logic                             s_want_response,
    input  wire logic [crt_pkg::TIME_W-1:0]       s_now_ms,

    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [crt_pkg::OUTCOME_W-1:0]         m_outcome,
    output logic                                  m_response_valid,
    output logic                                  m_response_ok,
    output logic [crt_pkg::SLOT_W-1:0]            m_response_slot,
    output logic [crt_pkg::SEQ_W-1:0]             m_response_seq,

    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [crt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [crt_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // Configuration registers.
    logic [crt_pkg::TIME_W-1:0] timeout_reg;
    logic [crt_pkg::MASK_W-1:0] silent_reg;

    // Input register holding the request under evaluation.
    logic           in_valid_reg;
    crt_pkg::item_t in_item_reg;

    // Result register.
    logic             out_valid_reg;
    crt_pkg::result_t out_result_reg;

    // Per-slot state. Only the control bits need a reset: sequence and time
    // are read solely while the slot is active, and become valid with it.
    logic [crt_pkg::NUM_SLOTS-1:0] slot_active_reg;
    logic [crt_pkg::NUM_SLOTS-1:0] slot_wants_reg;
    logic [crt_pkg::SEQ_W-1:0]     slot_seq_reg  [crt_pkg::NUM_SLOTS];
    logic [crt_pkg::TIME_W-1:0]    slot_time_reg [crt_pkg::NUM_SLOTS];

    logic                            advance;
    logic                            slot_in_range;
    logic [crt_pkg::SLOT_IDX_W-1:0]  slot_idx;
    crt_pkg::slot_entry_t            entry_sel;
    crt_pkg::result_t                eval_result;
    crt_pkg::slot_update_t           eval_update;

    // The request in the input register moves on whenever the result
    // register is empty or being emptied in this cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign slot_in_range = int'(in_item_reg.slot) < crt_pkg::NUM_SLOTS;
    assign slot_idx      = crt_pkg::SLOT_IDX_W'(in_item_reg.slot);

    // Read the addressed slot; an out-of-range slot sees an idle entry.
    always_comb begin
        entry_sel = '0;
        if (slot_in_range) begin
            entry_sel.active    = slot_active_reg[slot_idx];
            entry_sel.wants     = slot_wants_reg[slot_idx];
            entry_sel.seq       = slot_seq_reg[slot_idx];
            entry_sel.sent_time = slot_time_reg[slot_idx];
        end
    end

    crt_eval u_eval (
        .item        (in_item_reg),
        .entry       (entry_sel),
        .timeout_ms  (timeout_reg),
        .silent_mask (silent_reg),
        .result      (eval_result),
        .update      (eval_update)
    );

    // Configuration writes; an index beyond the register list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= crt_pkg::TIMEOUT_RESET;
            silent_reg  <= crt_pkg::SILENT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                crt_pkg::REG_TIMEOUT: timeout_reg <= cfg_data;
                crt_pkg::REG_SILENT:  silent_reg  <= cfg_data[crt_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake control and slot control bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            slot_active_reg <= '0;
            slot_wants_reg  <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            if (advance && eval_update.wr) begin
                slot_active_reg[slot_idx] <= eval_update.entry.active;
                slot_wants_reg[slot_idx]  <= eval_update.entry.wants;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.func          <= s_func;
            in_item_reg.slot          <= s_slot;
            in_item_reg.seq           <= s_seq;
            in_item_reg.reply_seq     <= s_reply_seq;
            in_item_reg.want_response <= s_want_response;
            in_item_reg.now_ms        <= s_now_ms;
        end
        if (advance) begin
            out_result_reg <= eval_result;
            if (eval_update.wr) begin
                slot_seq_reg[slot_idx]  <= eval_update.entry.seq;
                slot_time_reg[slot_idx] <= eval_update.entry.sent_time;
            end
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_outcome        = out_result_reg.outcome;
    assign m_response_valid = out_result_reg.response_valid;
    assign m_response_ok    = out_result_reg.response_ok;
    assign m_response_slot  = out_result_reg.response_slot;
    assign m_response_seq   = out_result_reg.response_seq;

endmodule

`default_nettype wire
